// ===== sv/bcc_pkg.sv =====
package bcc_pkg;

  localparam int TIME_WIDTH_DEFAULT = 48;
  localparam int STAMP_WIDTH = 48;
  localparam int REG_WIDTH = 24;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = 24'd50000;
  localparam logic [REG_WIDTH-1:0] DOUBLE_WINDOW_RESET = 24'd500000;
  localparam logic [REG_WIDTH-1:0] LONG_PRESS_RESET = 24'd2000000;
  localparam logic [REG_WIDTH-1:0] REPEAT_RESET = 24'd200000;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_WINDOW = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT = 3'd3;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_DOUBLE,
    KIND_LONG
  } event_kind_t;

  typedef struct packed {
    logic [STAMP_WIDTH-1:0] sample_time_us;
    logic                   pin_level;
  } sample_t;

  typedef struct packed {
    event_kind_t            event_kind;
    logic [STAMP_WIDTH-1:0] held_extra_us;
  } click_event_t;

endpackage

// ===== sv/button_click_classifier.sv =====
// channel  | direction | payload        | transaction when
// in       | input     | sample_t       | in_valid && in_ready
// out      | output    | click_event_t  | out_valid && out_ready
// cfg      | input     | index, data    | cfg_we (single-cycle write)
//
// one sample per cycle sustained unless out stalls; a sample is registered,
// then classified from the input register into the output register, where
// the button state updates too.
// a stalled output holds the classify stage; in_ready drops only while both
// the input register and a pending result are full.
// rst is synchronous and restores the register reset values and idle state.
module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sample_t                    in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output click_event_t               out_data,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_data
);

  localparam int WIDE = 64;

  logic [REG_WIDTH-1:0] debounce_us;
  logic [REG_WIDTH-1:0] double_click_window_us;
  logic [REG_WIDTH-1:0] long_press_us;
  logic [REG_WIDTH-1:0] repeat_interval_us;

  logic [TIME_WIDTH-1:0] press_stamp, press_stamp_next;
  logic [TIME_WIDTH-1:0] event_stamp, event_stamp_next;
  logic is_pressed, is_pressed_next;
  logic awaiting_second_click, awaiting_second_click_next;
  logic long_press_seen, long_press_seen_next;

  logic    s1_valid;
  sample_t s1_data;

  logic advance, fire;
  logic emit;
  click_event_t result;

  logic [WIDE-1:0] time_wide;
  logic [TIME_WIDTH-1:0] now, since_press, since_event, extra;
  logic [TIME_WIDTH-1:0] debounce_t, window_t, long_t, repeat_t;
  logic [WIDE-1:0] extra_wide;
  logic down;

  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us            <= DEBOUNCE_RESET;
      double_click_window_us <= DOUBLE_WINDOW_RESET;
      long_press_us          <= LONG_PRESS_RESET;
      repeat_interval_us     <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:      debounce_us <= cfg_data;
        REG_DOUBLE_WINDOW: double_click_window_us <= cfg_data;
        REG_LONG_PRESS:    long_press_us <= cfg_data;
        REG_REPEAT:        repeat_interval_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  assign time_wide   = {{(WIDE-STAMP_WIDTH){1'b0}}, s1_data.sample_time_us};
  assign now         = time_wide[TIME_WIDTH-1:0];
  assign down        = !s1_data.pin_level;
  assign since_press = now - press_stamp;
  assign since_event = now - event_stamp;
  assign debounce_t  = {{(TIME_WIDTH-REG_WIDTH){1'b0}}, debounce_us};
  assign window_t    = {{(TIME_WIDTH-REG_WIDTH){1'b0}}, double_click_window_us};
  assign long_t      = {{(TIME_WIDTH-REG_WIDTH){1'b0}}, long_press_us};
  assign repeat_t    = {{(TIME_WIDTH-REG_WIDTH){1'b0}}, repeat_interval_us};
  assign extra       = since_press - long_t;
  assign extra_wide  = {{(WIDE-TIME_WIDTH){1'b0}}, extra};

  always_comb begin
    press_stamp_next           = press_stamp;
    event_stamp_next           = event_stamp;
    is_pressed_next            = is_pressed;
    awaiting_second_click_next = awaiting_second_click;
    long_press_seen_next       = long_press_seen;
    emit                       = 1'b0;
    result.event_kind          = KIND_SINGLE;
    result.held_extra_us       = '0;
    if (since_press >= debounce_t) begin
      if (down != is_pressed) begin
        is_pressed_next = down;
        if (down) begin
          press_stamp_next     = now;
          long_press_seen_next = 1'b0;
        end else if (awaiting_second_click) begin
          awaiting_second_click_next = 1'b0;
          emit                       = 1'b1;
          result.event_kind          = KIND_DOUBLE;
        end else if (!long_press_seen) begin
          awaiting_second_click_next = 1'b1;
          event_stamp_next           = now;
        end
      end else if (awaiting_second_click && since_event > window_t) begin
        awaiting_second_click_next = 1'b0;
        emit                       = 1'b1;
        result.event_kind          = KIND_SINGLE;
      end else if (is_pressed && since_press > long_t) begin
        if (!long_press_seen) begin
          long_press_seen_next = 1'b1;
          event_stamp_next     = now;
          emit                 = 1'b1;
          result.event_kind    = KIND_LONG;
        end else if (since_event > repeat_t) begin
          event_stamp_next     = now;
          emit                 = 1'b1;
          result.event_kind    = KIND_LONG;
          result.held_extra_us = extra_wide[STAMP_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_stamp           <= '0;
      event_stamp           <= '0;
      is_pressed            <= 1'b0;
      awaiting_second_click <= 1'b0;
      long_press_seen       <= 1'b0;
      out_valid             <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
      if (fire) begin
        press_stamp           <= press_stamp_next;
        event_stamp           <= event_stamp_next;
        is_pressed            <= is_pressed_next;
        awaiting_second_click <= awaiting_second_click_next;
        long_press_seen       <= long_press_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data <= result;
    end
  end

endmodule
